>>> sv/mma_pkg.sv
// Shared types, constants and helper functions for the matrix multiply-accumulate unit.
`timescale 1ns / 1ps
package mma_pkg;

  localparam int DIM_MAX   = 8;
  localparam int DEPTH     = DIM_MAX * DIM_MAX;
  localparam int DIM_W     = $clog2(DIM_MAX);
  localparam int DIM_REG_W = 4;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = 40;
  localparam int CFG_IDX_W = 2;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_LEFT    = 2'd0,
    KIND_RIGHT   = 2'd1,
    KIND_ACC     = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_RIGHT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } state_t;

  // Operand store write request
  typedef struct packed {
    logic                     we_left;
    logic                     we_right;
    logic [IDX_W-1:0]         addr;
    logic signed [ELEM_W-1:0] data;
  } op_wr_t;

  // Multiply-accumulate pipeline controls
  typedef struct packed {
    logic first;    // accumulator read data valid: seed the running sum
    logic prod_en;  // operand read data valid: register the product
    logic add_en;   // product valid: add into the running sum
  } mac_ctrl_t;

  // Saturate a 40-bit value to the signed 16-bit range
  function automatic logic signed [ELEM_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    begin
      hi = ACC_W'(32767);
      lo = -ACC_W'(32768);
      if (v > hi) sat16 = 16'sh7FFF;
      else if (v < lo) sat16 = 16'sh8000;
      else sat16 = v[ELEM_W-1:0];
    end
  endfunction

  // Add a product to a sum and saturate to the signed 40-bit range
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] s,
                                                      input logic signed [PROD_W-1:0] p);
    logic signed [ACC_W:0] t;
    begin
      t = {s[ACC_W-1], s} + (ACC_W+1)'(p);
      if (t[ACC_W] != t[ACC_W-1])
        sat_add = t[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
        sat_add = t[ACC_W-1:0];
    end
  endfunction

  // Clamp a dimension register to 1..DIM_MAX
  function automatic logic [DIM_REG_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
    begin
      if (d == '0) clamp_dim = DIM_REG_W'(1);
      else if (d > DIM_REG_W'(DIM_MAX)) clamp_dim = DIM_REG_W'(DIM_MAX);
      else clamp_dim = d;
    end
  endfunction

endpackage

>>> sv/mma_operand_store.sv
// Left and right operand memories, one write port and one read port each.
`timescale 1ns / 1ps
module mma_operand_store (
  input  logic                              clk,
  input  mma_pkg::op_wr_t                   wr,
  input  logic                              rd_en,
  input  logic [mma_pkg::IDX_W-1:0]         raddr_left,
  input  logic [mma_pkg::IDX_W-1:0]         raddr_right,
  output logic signed [mma_pkg::ELEM_W-1:0] rdata_left,
  output logic signed [mma_pkg::ELEM_W-1:0] rdata_right
);
  import mma_pkg::*;

  logic signed [ELEM_W-1:0] left_mem  [DEPTH];
  logic signed [ELEM_W-1:0] right_mem [DEPTH];

  // Write ports
  always_ff @(posedge clk) begin
    if (wr.we_left) left_mem[wr.addr] <= wr.data;
    if (wr.we_right) right_mem[wr.addr] <= wr.data;
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_left  <= left_mem[raddr_left];
      rdata_right <= right_mem[raddr_right];
    end
  end

endmodule

>>> sv/mma_acc_store.sv
// Accumulator memory with per-entry valid bits so that reset reads as zero.
`timescale 1ns / 1ps
module mma_acc_store (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [mma_pkg::IDX_W-1:0]        waddr,
  input  logic signed [mma_pkg::ACC_W-1:0] wdata,
  input  logic                             rd_en,
  input  logic [mma_pkg::IDX_W-1:0]        raddr,
  output logic signed [mma_pkg::ACC_W-1:0] rdata
);
  import mma_pkg::*;

  logic signed [ACC_W-1:0] acc_mem [DEPTH];
  logic [DEPTH-1:0]        vld;
  logic signed [ACC_W-1:0] rd_word;
  logic                    rd_vld;

  // Data array
  always_ff @(posedge clk) begin
    if (we) acc_mem[waddr] <= wdata;
    if (rd_en) rd_word <= acc_mem[raddr];
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      if (rd_en) rd_vld <= vld[raddr];
    end
  end

  // Never-written entries read as zero
  assign rdata = rd_vld ? rd_word : '0;

endmodule

>>> sv/mma_mac.sv
// Multiply-accumulate unit: registered 16x16 product and saturating 40-bit running sum.
`timescale 1ns / 1ps
module mma_mac (
  input  logic                              clk,
  input  mma_pkg::mac_ctrl_t                ctrl,
  input  logic signed [mma_pkg::ACC_W-1:0]  acc_in,
  input  logic signed [mma_pkg::ELEM_W-1:0] a,
  input  logic signed [mma_pkg::ELEM_W-1:0] b,
  output logic signed [mma_pkg::ACC_W-1:0]  sum
);
  import mma_pkg::*;

  logic signed [PROD_W-1:0] prod;

  // Product stage
  always_ff @(posedge clk) begin
    if (ctrl.prod_en) prod <= a * b;
  end

  // Seed from the stored entry, then add products one at a time
  always_ff @(posedge clk) begin
    if (ctrl.first) sum <= acc_in;
    else if (ctrl.add_en) sum <= sat_add(sum, prod);
  end

endmodule

>>> sv/matrix_multiply_accumulate_unit.sv
// Top level of the matrix multiply-accumulate unit: sequencer, stores and result register.
//
// Input words arrive on s_tvalid/s_tready; s_tuser selects the kind: load a left
// element, load a right element, load an accumulator element, or compute. Loads are
// taken back to back while idle, with no output. A compute performs C += A * B over the
// dimensions held in the configuration registers (written through cfg_valid/cfg_ready,
// always ready) and then emits each updated C element in row-major order on
// m_tvalid/m_tready, with m_tlast on the final one.
// Each result element takes one operand read per inner step from the single read
// port of each operand memory, then the product and add stages drain before
// write-back; no new word is taken until the last result is in the output register.
// Results sit in one output register; when the receiver stalls the sequencer waits
// with the next element finished, so nothing is lost. A load word may be accepted
// while the final result of a compute is still waiting.
// Reset clears the accumulator (by valid bits, no clearing pass), sets all three
// dimensions to 8 and empties the output register. Operand memories are not cleared.
`timescale 1ns / 1ps
module matrix_multiply_accumulate_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mma_pkg::DIM_REG_W-1:0]      cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,  // elem_index[5:0], elem_value[45:6], 0
  input  logic [1:0]                         s_tuser,  // kind[1:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [47:0]                        m_tdata,  // out_index[5:0], out_value[45:6], 0
  output logic                               m_tlast
);
  import mma_pkg::*;

  // Configuration registers
  logic [DIM_REG_W-1:0] rows_left, inner_dim, cols_right;

  // Compute sequencer
  state_t               state, state_next;
  logic [DIM_REG_W-1:0] nr, nk, nc;
  logic [DIM_W-1:0]     r, c, i;
  logic                 p1, p1_first, p2;

  // Output register
  logic                    out_valid;
  logic [IDX_W-1:0]        out_index;
  logic signed [ACC_W-1:0] out_value;
  logic                    out_last;

  // Input word fields
  kind_t                   kind;
  logic [IDX_W-1:0]        elem_index;
  logic signed [ACC_W-1:0] elem_value;
  logic                    in_acc;

  // Addresses and control
  logic [IDX_W-1:0]        a_addr, b_addr, ri;
  logic                    issue, emit, slot_free, last_inner, last_col, last_row;
  op_wr_t                  op_wr;
  mac_ctrl_t               mac_ctrl;
  logic                    acc_we;
  logic [IDX_W-1:0]        acc_waddr;
  logic signed [ACC_W-1:0] acc_wdata, acc_rdata, sum;
  logic signed [ELEM_W-1:0] a_data, b_data;

  assign kind       = kind_t'(s_tuser);
  assign elem_index = s_tdata[IDX_W-1:0];
  assign elem_value = s_tdata[IDX_W+ACC_W-1:IDX_W];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_left  <= DIM_REG_W'(DIM_MAX);
      inner_dim  <= DIM_REG_W'(DIM_MAX);
      cols_right <= DIM_REG_W'(DIM_MAX);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS_LEFT:  rows_left  <= cfg_data;
        CFG_INNER_DIM:  inner_dim  <= cfg_data;
        CFG_COLS_RIGHT: cols_right <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flat addresses for the current step
  assign a_addr = IDX_W'(7'(r) * 7'(nk) + 7'(i));
  assign b_addr = IDX_W'(7'(i) * 7'(nc) + 7'(c));
  assign ri     = IDX_W'(7'(r) * 7'(nc) + 7'(c));

  assign last_inner = ({1'b0, i} == nk - DIM_REG_W'(1));
  assign last_col   = ({1'b0, c} == nc - DIM_REG_W'(1));
  assign last_row   = ({1'b0, r} == nr - DIM_REG_W'(1));
  assign slot_free  = !out_valid || m_tready;

  // Next state and step controls
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc && kind == KIND_COMPUTE) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (last_inner) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!p1 && !p2 && slot_free) begin
          emit = 1'b1;
          state_next = (last_col && last_row) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      p1       <= 1'b0;
      p1_first <= 1'b0;
      p2       <= 1'b0;
    end else begin
      state    <= state_next;
      p1       <= issue;
      p1_first <= issue && (i == '0);
      p2       <= p1;
    end
  end

  // Latch dimensions and advance the loop counters
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc && kind == KIND_COMPUTE) begin
      nr <= clamp_dim(rows_left);
      nk <= clamp_dim(inner_dim);
      nc <= clamp_dim(cols_right);
      r  <= '0;
      c  <= '0;
      i  <= '0;
    end else if (issue) begin
      i <= last_inner ? '0 : i + DIM_W'(1);
    end else if (emit) begin
      if (last_col) begin
        c <= '0;
        r <= r + DIM_W'(1);
      end else begin
        c <= c + DIM_W'(1);
      end
    end
  end

  // Element loads into the operand memories
  always_comb begin
    op_wr.we_left  = in_acc && kind == KIND_LEFT;
    op_wr.we_right = in_acc && kind == KIND_RIGHT;
    op_wr.addr     = elem_index;
    op_wr.data     = sat16(elem_value);
  end

  // Accumulator writes come from loads in idle or from write-back
  always_comb begin
    acc_we    = (in_acc && kind == KIND_ACC) || emit;
    acc_waddr = emit ? ri : elem_index;
    acc_wdata = emit ? sum : elem_value;
  end

  assign mac_ctrl.first   = p1_first;
  assign mac_ctrl.prod_en = p1;
  assign mac_ctrl.add_en  = p2;

  mma_operand_store u_ops (
    .clk         (clk),
    .wr          (op_wr),
    .rd_en       (issue),
    .raddr_left  (a_addr),
    .raddr_right (b_addr),
    .rdata_left  (a_data),
    .rdata_right (b_data)
  );

  mma_acc_store u_acc (
    .clk   (clk),
    .rst   (rst),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .rd_en (issue && i == '0),
    .raddr (ri),
    .rdata (acc_rdata)
  );

  mma_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .acc_in (acc_rdata),
    .a      (a_data),
    .b      (b_data),
    .sum    (sum)
  );

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index <= ri;
      out_value <= sum;
      out_last  <= last_col && last_row;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_value, out_index};
  assign m_tlast  = out_last;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the matrix multiply-accumulate unit.
`timescale 1ns / 1ps
module tb;
  import mma_pkg::*;

  // One updated accumulator element as it leaves the block
  typedef struct {
    logic [IDX_W-1:0] index;
    logic [ACC_W-1:0] value;
    logic             last;
  } acc_word_t;

  // One directed stimulus row; fixed marks a sum typed in by hand
  typedef struct {
    kind_t            kind;
    logic [IDX_W-1:0] index;
    logic [ACC_W-1:0] value;
    bit               fixed;
    logic [ACC_W-1:0] sum;
  } step_t;

  localparam longint ACC_TOP    = 64'sh7F_FFFF_FFFF;
  localparam longint ACC_BOTTOM = -64'sh80_0000_0000;
  localparam int     PHASES     = 7;
  localparam int     PHASE_LEN  = 6;
  localparam int     PRELOAD    = 16;
  localparam int     HOLD_AFTER = 40;
  localparam int     HOLD_LEN   = 300;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_REG_W-1:0] cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [47:0]          s_tdata;   // elem_index[5:0], elem_value[45:6], 0
  logic [1:0]           s_tuser;   // kind[1:0]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [47:0]          m_tdata;   // out_index[5:0], out_value[45:6], 0
  logic                 m_tlast;

  // Shadow copy of the block's matrices and dimension registers
  logic signed [ELEM_W-1:0] left_elems  [DEPTH];
  logic signed [ELEM_W-1:0] right_elems [DEPTH];
  logic signed [ACC_W-1:0]  acc_elems   [DEPTH];
  logic [DIM_REG_W-1:0]     rows_cfg;
  logic [DIM_REG_W-1:0]     inner_cfg;
  logic [DIM_REG_W-1:0]     cols_cfg;

  acc_word_t pending_sums [$];
  int        errors;
  int        results_seen;
  bit        calm;

  step_t steps [25] = '{
    '{KIND_LEFT,    6'd0,  40'd256,            1'b0, 40'd0},
    '{KIND_RIGHT,   6'd0,  40'd256,            1'b0, 40'd0},
    '{KIND_COMPUTE, 6'd0,  40'd0,              1'b1, 40'h00_0001_0000},
    '{KIND_COMPUTE, 6'd63, 40'hFF_FFFF_FFFF,   1'b1, 40'h00_0002_0000},
    '{KIND_ACC,     6'd0,  40'h7F_FFFF_FFFF,   1'b0, 40'd0},
    '{KIND_LEFT,    6'd0,  40'h7F_FFFF_FFFF,   1'b0, 40'd0},
    '{KIND_RIGHT,   6'd0,  40'h00_0000_8000,   1'b0, 40'd0},
    '{KIND_COMPUTE, 6'd0,  40'd0,              1'b1, 40'h7F_FFFF_FFFF},
    '{KIND_ACC,     6'd0,  40'h80_0000_0000,   1'b0, 40'd0},
    '{KIND_LEFT,    6'd0,  40'h80_0000_0000,   1'b0, 40'd0},
    '{KIND_COMPUTE, 6'd0,  40'd0,              1'b1, 40'h80_0000_0000},
    '{KIND_RIGHT,   6'd0,  40'hFF_FFFF_FFFF,   1'b0, 40'd0},
    '{KIND_COMPUTE, 6'd0,  40'd0,              1'b0, 40'd0},
    '{KIND_LEFT,    6'd63, 40'h00_0000_7FFF,   1'b0, 40'd0},
    '{KIND_RIGHT,   6'd63, 40'hFF_FFFF_8000,   1'b0, 40'd0},
    '{KIND_ACC,     6'd63, 40'h7F_FFFF_FFFF,   1'b0, 40'd0},
    '{KIND_ACC,     6'd0,  40'd0,              1'b0, 40'd0},
    '{KIND_LEFT,    6'd0,  40'hFF_FFFF_FF00,   1'b0, 40'd0},
    '{KIND_RIGHT,   6'd0,  40'd256,            1'b0, 40'd0},
    '{KIND_COMPUTE, 6'd0,  40'd0,              1'b1, 40'hFF_FFFF_0000},
    '{KIND_LEFT,    6'd0,  40'hFF_FFFF_7FFF,   1'b0, 40'd0},
    '{KIND_RIGHT,   6'd0,  40'h00_0000_7FFF,   1'b0, 40'd0},
    '{KIND_COMPUTE, 6'd0,  40'd0,              1'b0, 40'd0},
    '{KIND_ACC,     6'd42, 40'h55_5555_5555,   1'b0, 40'd0},
    '{KIND_ACC,     6'd21, 40'hAA_AAAA_AAAA,   1'b0, 40'd0}
  };

  matrix_multiply_accumulate_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Dimensions outside 1..DIM_MAX act as the nearest bound
  function automatic int eff_dim(input logic [DIM_REG_W-1:0] d);
    if (d == '0) return 1;
    if (d > DIM_REG_W'(DIM_MAX)) return DIM_MAX;
    return int'(d);
  endfunction

  // Gap length for either side: mostly none, some short, a few long
  function automatic int idle_cycles();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ACC_W-1:0] random_value(input kind_t k);
    int          p;
    logic [63:0] wide;
    p = $urandom_range(0, 9);
    wide = {$urandom, $urandom};
    if (p == 9) return wide[1] ? 40'h7F_FFFF_FFFF : 40'h80_0000_0000;
    if (p == 8) return wide[ACC_W-1:0];
    if (k == KIND_ACC) return ACC_W'($signed(wide[23:0]));
    if (p >= 6) return ACC_W'($signed(wide[15:0]));
    return ACC_W'($signed(wide[11:0]));
  endfunction

  // Apply one accepted word to the shadow state and queue the sums it emits
  task automatic mac_update(input kind_t k, input logic [IDX_W-1:0] idx,
                            input logic [ACC_W-1:0] raw);
    longint    v;
    longint    sum;
    int        nr;
    int        nk;
    int        nc;
    acc_word_t w;
    v = longint'($signed(raw));
    case (k)
      KIND_LEFT:  left_elems[idx] = ELEM_W'(clip(v, -32768, 32767));
      KIND_RIGHT: right_elems[idx] = ELEM_W'(clip(v, -32768, 32767));
      KIND_ACC:   acc_elems[idx] = raw;
      default: begin
        nr = eff_dim(rows_cfg);
        nk = eff_dim(inner_cfg);
        nc = eff_dim(cols_cfg);
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            sum = longint'(acc_elems[r * nc + c]);
            for (int i = 0; i < nk; i++) begin
              sum = clip(sum + longint'(left_elems[r * nk + i]) *
                         longint'(right_elems[i * nc + c]), ACC_BOTTOM, ACC_TOP);
            end
            acc_elems[r * nc + c] = ACC_W'(sum);
            w.index = IDX_W'(r * nc + c);
            w.value = ACC_W'(sum);
            w.last  = (r == nr - 1) && (c == nc - 1);
            pending_sums.push_back(w);
          end
        end
      end
    endcase
  endtask

  // Offer one word after a gap, hold it until accepted, then predict
  task automatic send_word(input kind_t k, input logic [IDX_W-1:0] idx,
                           input logic [ACC_W-1:0] val, input int gap,
                           input bit fixed, input logic [ACC_W-1:0] sum);
    acc_word_t w;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {2'b00, val, idx};
    do @(posedge clk); while (!s_tready);
    mac_update(k, idx, val);
    if (fixed) begin
      w = pending_sums.pop_back();
      w.value = sum;
      pending_sums.push_back(w);
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Drain the block, then write all three dimension registers
  task automatic write_dims(input logic [DIM_REG_W-1:0] r, input logic [DIM_REG_W-1:0] k,
                            input logic [DIM_REG_W-1:0] c);
    logic [DIM_REG_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0] reg_idx;
    vals = '{r, k, c};
    release_input();
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    for (int j = 0; j < 3; j++) begin
      reg_idx = (j == 0) ? CFG_ROWS_LEFT : (j == 1) ? CFG_INNER_DIM : CFG_COLS_RIGHT;
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx;
      cfg_data  <= vals[j];
      do @(posedge clk); while (!cfg_ready);
      case (reg_idx)
        CFG_ROWS_LEFT:  rows_cfg = vals[j];
        CFG_INNER_DIM:  inner_cfg = vals[j];
        CFG_COLS_RIGHT: cols_cfg = vals[j];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compare each accepted result with the oldest predicted sum
  always @(posedge clk) begin
    acc_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, actual index %0d value %h last %b",
                 $time, m_tdata[5:0], m_tdata[45:6], m_tlast);
      end else begin
        w = pending_sums.pop_front();
        if (m_tdata[5:0] !== w.index) begin
          errors++;
          $display("%0t out_index: expected %0d, actual %0d", $time, w.index, m_tdata[5:0]);
        end
        if (m_tdata[45:6] !== w.value) begin
          errors++;
          $display("%0t out_value: expected %h, actual %h", $time, w.value, m_tdata[45:6]);
        end
        if (m_tlast !== w.last) begin
          errors++;
          $display("%0t last: expected %b, actual %b", $time, w.last, m_tlast);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input
  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = idle_cycles();
      end
    end
  end

  // Stimulus
  initial begin
    int   p;
    kind_t k;
    logic [DIM_REG_W-1:0] dr;
    logic [DIM_REG_W-1:0] dk;
    logic [DIM_REG_W-1:0] dc;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ROWS_LEFT;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = KIND_LEFT;
    errors       = 0;
    results_seen = 0;
    calm         = 1'b0;
    rows_cfg     = DIM_REG_W'(DIM_MAX);
    inner_cfg    = DIM_REG_W'(DIM_MAX);
    cols_cfg     = DIM_REG_W'(DIM_MAX);
    foreach (acc_elems[n]) acc_elems[n] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load the operand elements that every shape below can read
    for (int n = 0; n < PRELOAD; n++)
      send_word(KIND_LEFT, IDX_W'(n), random_value(KIND_LEFT), 0, 1'b0, '0);
    for (int n = 0; n < PRELOAD; n++)
      send_word(KIND_RIGHT, IDX_W'(n), random_value(KIND_RIGHT), 0, 1'b0, '0);

    // Directed rows on single-element matrices
    write_dims(4'd1, 4'd1, 4'd1);
    foreach (steps[n])
      send_word(steps[n].kind, steps[n].index, steps[n].value, idle_cycles(),
                steps[n].fixed, steps[n].sum);

    // Random phases over a spread of shapes, extremes first; each shape keeps
    // rows * inner and inner * cols within the loaded operand elements
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin dr = 4'd8;  dk = 4'd1;  dc = 4'd8;  end
        1:       begin dr = 4'd0;  dk = 4'd0;  dc = 4'd0;  end
        2:       begin dr = 4'd15; dk = 4'd1;  dc = 4'd15; end
        3:       begin dr = 4'd2;  dk = 4'd8;  dc = 4'd2;  end
        4:       begin dr = 4'd4;  dk = 4'd4;  dc = 4'd4;  end
        5:       begin dr = 4'd1;  dk = 4'd15; dc = 4'd2;  end
        default: begin
          do begin
            dr = DIM_REG_W'($urandom_range(0, 15));
            dk = DIM_REG_W'($urandom_range(0, 15));
            dc = DIM_REG_W'($urandom_range(0, 15));
          end while (eff_dim(dr) * eff_dim(dk) > PRELOAD ||
                     eff_dim(dk) * eff_dim(dc) > PRELOAD);
        end
      endcase
      write_dims(dr, dk, dc);
      calm = (ph == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Early compute in each phase, so later words wait behind its results
        if (n == 1) begin
          k = KIND_COMPUTE;
        end else begin
          p = $urandom_range(0, 9);
          if (p < 3) k = KIND_LEFT;
          else if (p < 6) k = KIND_RIGHT;
          else if (p < 8) k = KIND_ACC;
          else k = KIND_COMPUTE;
        end
        send_word(k, IDX_W'($urandom_range(0, DEPTH - 1)), random_value(k),
                  idle_cycles(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    // Drain and report
    release_input();
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
sv/mma_pkg.sv
sv/mma_operand_store.sv
sv/mma_acc_store.sv
sv/mma_mac.sv
sv/matrix_multiply_accumulate_unit.sv
tb/sv/tb.sv
